@@ hdl/pdf_pkg.sv @@
package pdf_pkg;

	localparam int WINDOW = 128;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int PCT_W  = 7;
	localparam int RUN_W  = 8;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_PCT_MICROSLEEP = 3'd0,
		REG_PCT_DROWSY     = 3'd1,
		REG_PCT_PRE_DROWSY = 3'd2,
		REG_RUN_MICROSLEEP = 3'd3,
		REG_RUN_DROWSY     = 3'd4,
		REG_RUN_PRE_DROWSY = 3'd5,
		REG_RISE_HOLD      = 3'd6,
		REG_FALL_HOLD      = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		LVL_AWAKE      = 2'd0,
		LVL_PRE_DROWSY = 2'd1,
		LVL_DROWSY     = 2'd2,
		LVL_MICROSLEEP = 2'd3
	} level_t;

	typedef struct packed {
		logic [PCT_W-1:0] pct_microsleep;
		logic [PCT_W-1:0] pct_drowsy;
		logic [PCT_W-1:0] pct_pre_drowsy;
		logic [RUN_W-1:0] run_microsleep;
		logic [RUN_W-1:0] run_drowsy;
		logic [RUN_W-1:0] run_pre_drowsy;
		logic [RUN_W-1:0] rise_hold;
		logic [RUN_W-1:0] fall_hold;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] closed;
		logic [CNT_W-1:0] samples;
		logic [RUN_W-1:0] run;
	} counts_t;

	localparam cfg_t CFG_RESET = '{
		pct_microsleep: 7'd70,
		pct_drowsy:     7'd40,
		pct_pre_drowsy: 7'd20,
		run_microsleep: 8'd30,
		run_drowsy:     8'd15,
		run_pre_drowsy: 8'd5,
		rise_hold:      8'd10,
		fall_hold:      8'd10
	};

endpackage

@@ hdl/pdf_cfg_regs.sv @@
module pdf_cfg_regs import pdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PCT_MICROSLEEP: cfg_q.pct_microsleep <= cfg_data[PCT_W-1:0];
				REG_PCT_DROWSY:     cfg_q.pct_drowsy     <= cfg_data[PCT_W-1:0];
				REG_PCT_PRE_DROWSY: cfg_q.pct_pre_drowsy <= cfg_data[PCT_W-1:0];
				REG_RUN_MICROSLEEP: cfg_q.run_microsleep <= cfg_data[RUN_W-1:0];
				REG_RUN_DROWSY:     cfg_q.run_drowsy     <= cfg_data[RUN_W-1:0];
				REG_RUN_PRE_DROWSY: cfg_q.run_pre_drowsy <= cfg_data[RUN_W-1:0];
				REG_RISE_HOLD:      cfg_q.rise_hold      <= cfg_data[RUN_W-1:0];
				REG_FALL_HOLD:      cfg_q.fall_hold      <= cfg_data[RUN_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

@@ hdl/pdf_window.sv @@
module pdf_window import pdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    eye_closed,
	input  logic    s1_take,
	output logic    s1_valid,
	output counts_t counts
);

	// flag history; entries are only read once the window is full
	logic             ring_mem [WINDOW];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] head_d;
	logic             old_q;
	logic             valid_q;
	counts_t          cnt_q;
	counts_t          cnt_d;
	logic             accept;
	logic             full;

	assign in_ready = !valid_q || s1_take;
	assign accept   = in_valid && in_ready;
	assign s1_valid = valid_q;
	assign counts   = cnt_q;
	assign full     = (cnt_q.samples == CNT_W'(WINDOW));

	always_comb begin
		head_d = head_q;
		if (accept) begin
			if (head_q == PTR_W'(WINDOW - 1))
				head_d = '0;
			else
				head_d = head_q + PTR_W'(1);
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (!full) begin
			cnt_d.samples = cnt_q.samples + CNT_W'(1);
			if (eye_closed)
				cnt_d.closed = cnt_q.closed + CNT_W'(1);
		end else if (eye_closed && !old_q) begin
			cnt_d.closed = cnt_q.closed + CNT_W'(1);
		end else if (!eye_closed && old_q && (cnt_q.closed != '0)) begin
			cnt_d.closed = cnt_q.closed - CNT_W'(1);
		end
		if (eye_closed) begin
			if (cnt_q.run != '1)
				cnt_d.run = cnt_q.run + RUN_W'(1);
		end else begin
			cnt_d.run = '0;
		end
	end

	// read the slot the next word will overwrite; bypass when it is the one being written
	always_ff @(posedge clk) begin
		if (accept)
			ring_mem[head_q] <= eye_closed;
		if (accept && (head_d == head_q))
			old_q <= eye_closed;
		else
			old_q <= ring_mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			if (accept) begin
				cnt_q   <= cnt_d;
				valid_q <= 1'b1;
			end else if (s1_take) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/pdf_level.sv @@
module pdf_level import pdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        s1_valid,
	output logic        s1_take,
	input  counts_t     counts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  level,
	output logic [7:0]  closed_in_window,
	output logic [7:0]  samples_in_window,
	output logic [7:0]  closed_run
);

	localparam int PROD_W = CNT_W + PCT_W;

	level_t           com_q;
	level_t           cand_q;
	logic [RUN_W-1:0] hold_q;
	level_t           com_d;
	level_t           cand_d;
	logic [RUN_W-1:0] hold_d;
	logic [RUN_W-1:0] hold_inc;
	logic [RUN_W-1:0] need;
	level_t           raw;
	logic [PROD_W-1:0] lhs;
	logic [PROD_W-1:0] rhs_ms;
	logic [PROD_W-1:0] rhs_dr;
	logic [PROD_W-1:0] rhs_pd;
	logic              hit_ms;
	logic              hit_dr;
	logic              hit_pd;
	logic              ov_q;
	logic [1:0]        lvl_q;
	logic [7:0]        closed_q;
	logic [7:0]        samples_q;
	logic [7:0]        run_q;

	assign s1_take = s1_valid && (!ov_q || out_ready);

	assign lhs    = PROD_W'(counts.closed) * PROD_W'(100);
	assign rhs_ms = PROD_W'(cfg.pct_microsleep) * PROD_W'(counts.samples);
	assign rhs_dr = PROD_W'(cfg.pct_drowsy) * PROD_W'(counts.samples);
	assign rhs_pd = PROD_W'(cfg.pct_pre_drowsy) * PROD_W'(counts.samples);

	assign hit_ms = (lhs >= rhs_ms) || (counts.run >= cfg.run_microsleep);
	assign hit_dr = (lhs >= rhs_dr) || (counts.run >= cfg.run_drowsy);
	assign hit_pd = (lhs >= rhs_pd) || (counts.run >= cfg.run_pre_drowsy);

	always_comb begin
		if (hit_ms)
			raw = LVL_MICROSLEEP;
		else if (hit_dr)
			raw = LVL_DROWSY;
		else if (hit_pd)
			raw = LVL_PRE_DROWSY;
		else
			raw = LVL_AWAKE;
	end

	assign need     = (raw > com_q) ? cfg.rise_hold : cfg.fall_hold;
	assign hold_inc = (hold_q != '1) ? hold_q + RUN_W'(1) : hold_q;

	always_comb begin
		com_d  = com_q;
		cand_d = cand_q;
		hold_d = hold_q;
		if (raw != com_q) begin
			if (raw == cand_q) begin
				if (hold_inc >= need) begin
					com_d  = raw;
					hold_d = '0;
				end else begin
					hold_d = hold_inc;
				end
			end else begin
				cand_d = raw;
				hold_d = RUN_W'(1);
			end
		end else begin
			cand_d = com_q;
			hold_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			com_q  <= LVL_AWAKE;
			cand_q <= LVL_AWAKE;
			hold_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (s1_take) begin
				com_q  <= com_d;
				cand_q <= cand_d;
				hold_q <= hold_d;
				ov_q   <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			lvl_q     <= com_d;
			closed_q  <= 8'(counts.closed);
			samples_q <= 8'(counts.samples);
			run_q     <= 8'(counts.run);
		end
	end

	assign out_valid         = ov_q;
	assign level             = lvl_q;
	assign closed_in_window  = closed_q;
	assign samples_in_window = samples_q;
	assign closed_run        = run_q;

endmodule

@@ hdl/perclos_drowsiness_fsm_unit.sv @@
// Throughput is one word per cycle unless out_ready stalls the stage 2 result register.
// The flag window is a 1-bit memory read one slot ahead.
// Stage 1 updates window counts and run length, stage 2 the level and hysteresis.
// Reset (arst_n, async, active low) clears counts, level state and loads default thresholds.
// No clearing pass: window flags are only read once every slot has been written.
module perclos_drowsiness_fsm_unit import pdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              eye_closed,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        level,
	output logic [7:0]        closed_in_window,
	output logic [7:0]        samples_in_window,
	output logic [7:0]        closed_run,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	counts_t counts;
	logic    s1_valid;
	logic    s1_take;

	pdf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdf_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.eye_closed (eye_closed),
		.s1_take    (s1_take),
		.s1_valid   (s1_valid),
		.counts     (counts)
	);

	pdf_level u_level (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.s1_valid          (s1_valid),
		.s1_take           (s1_take),
		.counts            (counts),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.level             (level),
		.closed_in_window  (closed_in_window),
		.samples_in_window (samples_in_window),
		.closed_run        (closed_run)
	);

endmodule
